// ----- rtl/cawt_pkg.sv -----
// package: character codes and result entry type for the word tokeniser
`timescale 1ns / 1ps

package cawt_pkg;

	// character codes
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	// result queue geometry
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW    = 2;
	localparam int RQ_CW    = 3;

	// one result beat
	typedef struct packed {
		logic [7:0] out_char;
		logic       word_start;
		logic       last;
	} result_t;

endpackage

// ----- rtl/comment_aware_word_tokenizer.sv -----
// top level: comment-aware word tokeniser, one character per beat in
`timescale 1ns / 1ps

// Usage
// Input channel: item_valid / item_stall carry ch and line_end, one character
// of a text line per beat; a beat with line_end high closes the line.
// Output channel: res_valid / res_stall carry out_char, word_start and last,
// one word character per beat; last marks the final result of an input beat.
// An input beat gives zero, one or two results (two when a held-back slash
// is released ahead of the next kept character).
// An input beat lands in the input register, is decoded there in one pass
// against the tokeniser state, and its results are written into the result
// queue, from whose head they are presented on the output channel.
// Throughput: one input beat per cycle while the result queue has room for
// two more results; the output side moves one result per cycle, one move
// per result. A four-entry result queue decouples the two sides.
// Reset clears the tokeniser state, the input register and the result queue.
// When the receiver stalls, the head result holds steady; once the queue can
// no longer take two more results the input register stops and item_stall
// rises.
module comment_aware_word_tokenizer
	import cawt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] ch,
	input  logic       line_end,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] out_char,
	output logic       word_start,
	output logic       last
);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       line_end_s1;

	// tokeniser state
	logic block_comment_q, skip_rest_q, prev_slash_q, prev_star_q;
	logic just_closed_q, in_quote_q, word_open_q;

	// next state and results
	logic bc_n, skip_n, ps_n, pst_n, jcc_n, iq_n, wo_n;
	logic is_space, is_single, is_quote, is_slash, is_star, is_hash;
	logic [1:0] res_n;
	result_t    res0, res1;

	// result queue
	result_t          rq_q [RQ_DEPTH];
	logic [RQ_AW-1:0] rd_ptr_q, wr_ptr_q, wr_ptr_p1;
	logic [RQ_CW-1:0] count_q;
	logic             room, advance, pop;

	assign room       = (count_q <= RQ_CW'(RQ_DEPTH - 2));
	assign advance    = valid_s1 && room;
	assign item_stall = valid_s1 && !room;
	assign pop        = res_valid && !res_stall;

	// input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			ch_s1       <= ch;
			line_end_s1 <= line_end;
		end
	end

	// character classes
	always_comb begin
		is_space  = (ch_s1 == CH_SPACE) || (ch_s1 == CH_TAB);
		is_single = (ch_s1 == CH_EQUAL) || (ch_s1 == CH_LBRACE) || (ch_s1 == CH_RBRACE) ||
			(ch_s1 == CH_LPAREN) || (ch_s1 == CH_RPAREN) || (ch_s1 == CH_SEMI) ||
			(ch_s1 == CH_COMMA);
		is_quote  = (ch_s1 == CH_DQUOTE) || (ch_s1 == CH_SQUOTE);
		is_slash  = (ch_s1 == CH_SLASH);
		is_star   = (ch_s1 == CH_STAR);
		is_hash   = (ch_s1 == CH_HASH);
	end

	// single-pass tokeniser decode
	always_comb begin
		logic sp, sg;
		bc_n   = block_comment_q;
		skip_n = skip_rest_q;
		ps_n   = prev_slash_q;
		pst_n  = prev_star_q;
		jcc_n  = just_closed_q;
		iq_n   = in_quote_q;
		wo_n   = word_open_q;
		res_n  = 2'd0;
		res0   = '0;
		res1   = '0;
		sp     = is_space;
		sg     = is_single;
		if (line_end_s1) begin
			skip_n = 1'b0;
			ps_n   = 1'b0;
			pst_n  = 1'b0;
			jcc_n  = 1'b0;
			iq_n   = 1'b0;
			wo_n   = 1'b0;
		end else if (!skip_rest_q) begin
			if (prev_slash_q && is_slash) begin
				skip_n = 1'b1;
			end else begin
				// star-slash closes a comment
				if (prev_star_q && is_slash) begin
					ps_n  = 1'b0;
					pst_n = 1'b0;
					jcc_n = 1'b1;
					bc_n  = 1'b0;
				end
				if (ps_n && is_star) begin
					bc_n = 1'b1;
				end
				if (is_hash) begin
					skip_n = 1'b1;
				end else if (!bc_n && is_slash) begin
					// hold the slash back
					ps_n = 1'b1;
				end else begin
					if (!bc_n) begin
						// release a held slash
						if (ps_n && !jcc_n) begin
							res0.out_char   = CH_SLASH;
							res0.word_start = !wo_n;
							wo_n            = 1'b1;
							res_n           = 2'd1;
						end
						if (is_quote) begin
							wo_n = 1'b0;
							iq_n = !iq_n;
							sp   = 1'b1;
							sg   = 1'b0;
						end
						if ((!iq_n && !sp) || (iq_n && !is_quote) || (!iq_n && sg)) begin
							if (res_n == 2'd0) begin
								res0.out_char   = ch_s1;
								res0.word_start = (!iq_n && sg) || !wo_n;
							end else begin
								res1.out_char   = ch_s1;
								res1.word_start = (!iq_n && sg) || !wo_n;
							end
							res_n = res_n + 2'd1;
						end
						if (!iq_n && (sp || sg)) begin
							wo_n = 1'b0;
						end else if (!iq_n || !is_quote) begin
							wo_n = 1'b1;
						end
						jcc_n = 1'b0;
					end
					ps_n  = is_slash;
					pst_n = is_star;
				end
			end
		end
		res0.last = (res_n == 2'd1);
		res1.last = 1'b1;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_comment_q <= 1'b0;
			skip_rest_q     <= 1'b0;
			prev_slash_q    <= 1'b0;
			prev_star_q     <= 1'b0;
			just_closed_q   <= 1'b0;
			in_quote_q      <= 1'b0;
			word_open_q     <= 1'b0;
		end else if (advance) begin
			block_comment_q <= bc_n;
			skip_rest_q     <= skip_n;
			prev_slash_q    <= ps_n;
			prev_star_q     <= pst_n;
			just_closed_q   <= jcc_n;
			in_quote_q      <= iq_n;
			word_open_q     <= wo_n;
		end
	end

	// result queue pointers and fill count
	assign wr_ptr_p1 = wr_ptr_q + RQ_AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + RQ_AW'(1);
			end
			if (advance) begin
				wr_ptr_q <= wr_ptr_q + RQ_AW'(res_n);
			end
			count_q <= count_q + (advance ? RQ_CW'(res_n) : '0) - RQ_CW'(pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (advance && (res_n != 2'd0)) begin
			rq_q[wr_ptr_q] <= res0;
		end
		if (advance && (res_n == 2'd2)) begin
			rq_q[wr_ptr_p1] <= res1;
		end
	end

	// output beat
	assign res_valid  = (count_q != '0);
	assign out_char   = rq_q[rd_ptr_q].out_char;
	assign word_start = rq_q[rd_ptr_q].word_start;
	assign last       = rq_q[rd_ptr_q].last;

endmodule
